FILE: rtl/plbl_pkg.sv
// shared types and constants for the planar tile rectangle blitter
// no dependencies

package plbl_pkg;

	localparam int TILE_DIM = 8;
	localparam int COL_W = $clog2(TILE_DIM);

	localparam logic [12:0] FRAME_MAX = 13'd4096;
	localparam logic [12:0] FRAME_W_RST = 13'd256;
	localparam logic [12:0] FRAME_H_RST = 13'd240;

	// configuration register indexes
	typedef enum logic [0:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	// one lane's result: horizontal span of its pixel square
	typedef struct packed {
		logic        emit;
		logic [11:0] left;
		logic [12:0] right;
		logic [31:0] color;
	} lane_rect_t;

	// one decoded tile row handed to the merge stage
	typedef struct packed {
		lane_rect_t [TILE_DIM-1:0] lane;
		logic [11:0]               top;
		logic [12:0]               bottom;
		logic                      last_row;
	} row_t;

	typedef struct packed {
		logic [11:0] left;
		logic [11:0] top;
		logic [12:0] right;
		logic [12:0] bottom;
		logic [31:0] color;
	} rect_t;

endpackage

FILE: rtl/plbl_ifs.sv
// valid/ready channels for tile requests and rectangle requests
// standalone, no package needed

interface plbl_tile_if;
	logic               valid;
	logic               ready;
	logic [63:0]        plane_low_rows;
	logic [63:0]        plane_high_rows;
	logic signed [15:0] origin_x;
	logic signed [15:0] origin_y;
	logic [3:0]         pixel_scale;
	logic               mirror_x;
	logic               mirror_y;
	logic [31:0]        color_one;
	logic [31:0]        color_two;
	logic [31:0]        color_three;

	modport source(output valid, plane_low_rows, plane_high_rows, origin_x, origin_y,
		pixel_scale, mirror_x, mirror_y, color_one, color_two, color_three, input ready);
	modport sink(input valid, plane_low_rows, plane_high_rows, origin_x, origin_y,
		pixel_scale, mirror_x, mirror_y, color_one, color_two, color_three, output ready);
endinterface

interface plbl_rect_if;
	logic        valid;
	logic        ready;
	logic [11:0] rect_left;
	logic [11:0] rect_top;
	logic [12:0] rect_right;
	logic [12:0] rect_bottom;
	logic [31:0] fill_color;
	logic        last_rect;

	modport source(output valid, rect_left, rect_top, rect_right, rect_bottom, fill_color,
		last_rect, input ready);
	modport sink(input valid, rect_left, rect_top, rect_right, rect_bottom, fill_color,
		last_rect, output ready);
endinterface

FILE: rtl/planar_tile_rect_blitter.sv
// planar tile rectangle blitter, top level: row sequencer, eight column lanes, merge stage
// uses plbl_pkg, plbl_ifs, plbl_lane, plbl_merge
//
// usage:
//   tile_in takes one 8x8 two-plane tile request with position, scale, flips
//   and three colors. rect_out gives one fill rectangle request per visible
//   pixel, in screen raster order, with last_rect on the tile's final one.
//   a tile that draws nothing gives no request at all.
//   cfg_we/cfg_index/cfg_data write frame_width (index 0) and frame_height
//   (index 1); change them only while no tile is in flight.
// timing:
//   lanes decode a tile row per cycle while the merge stage takes rows, then one
//   rectangle leaves per cycle while rect_out is ready. the next tile is taken once
//   the last rectangle reaches the output register; each rectangle passes a hold
//   register and then the output register, one being held back to mark the last.
// reset: frame size goes to 256 x 240, all channels empty.
// stall: a stalled rect_out holds its request and back-pressures the merge
//   stage and row sequencer; nothing is dropped.

module planar_tile_rect_blitter (
	input  logic        clk,
	input  logic        arst_n,
	plbl_tile_if.sink   tile_in,
	plbl_rect_if.source rect_out,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [12:0] cfg_data
);
	import plbl_pkg::*;

	logic [12:0]        frame_w_q;
	logic [12:0]        frame_h_q;
	logic [12:0]        fw_lim;
	logic [12:0]        fh_lim;

	logic               busy_q;
	logic               issue_q;
	logic [COL_W-1:0]   row_q;
	logic [63:0]        low_q;
	logic [63:0]        high_q;
	logic signed [15:0] ox_q;
	logic signed [15:0] oy_q;
	logic [3:0]         scale_q;
	logic               mx_q;
	logic               my_q;
	logic [31:0]        c1_q;
	logic [31:0]        c2_q;
	logic [31:0]        c3_q;

	logic [COL_W-1:0]   src_row;
	logic [7:0]         p0;
	logic [7:0]         p1;
	logic [6:0]         y_off;
	logic signed [17:0] y0;
	logic signed [17:0] y1;
	logic signed [17:0] y0_clip;
	logic signed [17:0] y1_clip;
	logic signed [17:0] fh_ext;
	logic               row_ok;

	lane_rect_t [TILE_DIM-1:0] lanes;
	row_t               row;
	logic               row_valid;
	logic               row_ready;
	logic               tile_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_w_q <= FRAME_W_RST;
			frame_h_q <= FRAME_H_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_FRAME_WIDTH:  frame_w_q <= cfg_data;
				REG_FRAME_HEIGHT: frame_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign fw_lim = (frame_w_q > FRAME_MAX) ? FRAME_MAX : frame_w_q;
	assign fh_lim = (frame_h_q > FRAME_MAX) ? FRAME_MAX : frame_h_q;

	assign tile_in.ready = !busy_q;
	assign row_valid = issue_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			issue_q <= 1'b0;
			row_q <= '0;
		end else begin
			if (tile_in.valid && !busy_q) begin
				busy_q <= 1'b1;
				issue_q <= 1'b1;
				row_q <= '0;
			end else begin
				if (issue_q && row_ready) begin
					row_q <= row_q + COL_W'(1);
					if (row_q == COL_W'(TILE_DIM - 1)) begin
						issue_q <= 1'b0;
					end
				end
				if (tile_done) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tile_in.valid && !busy_q) begin
			low_q <= tile_in.plane_low_rows;
			high_q <= tile_in.plane_high_rows;
			ox_q <= tile_in.origin_x;
			oy_q <= tile_in.origin_y;
			scale_q <= tile_in.pixel_scale;
			mx_q <= tile_in.mirror_x;
			my_q <= tile_in.mirror_y;
			c1_q <= tile_in.color_one;
			c2_q <= tile_in.color_two;
			c3_q <= tile_in.color_three;
		end
	end

	// vertical span shared by the whole row
	assign src_row = my_q ? (COL_W'(TILE_DIM - 1) - row_q) : row_q;
	assign p0 = low_q[src_row*8 +: 8];
	assign p1 = high_q[src_row*8 +: 8];
	assign y_off = 7'({4'd0, row_q} * {3'd0, scale_q});
	assign y0 = {{2{oy_q[15]}}, oy_q} + {11'd0, y_off};
	assign y1 = y0 + {14'd0, scale_q};
	assign fh_ext = {5'd0, fh_lim};
	assign y0_clip = y0[17] ? 18'sd0 : y0;
	assign y1_clip = (y1 > fh_ext) ? fh_ext : y1;
	assign row_ok = y0_clip < y1_clip;

	for (genvar g = 0; g < TILE_DIM; g++) begin : g_lane
		plbl_lane u_lane (
			.plane_low   (p0),
			.plane_high  (p1),
			.col         (COL_W'(g)),
			.mirror_x    (mx_q),
			.origin_x    (ox_q),
			.pixel_scale (scale_q),
			.frame_w     (fw_lim),
			.color_one   (c1_q),
			.color_two   (c2_q),
			.color_three (c3_q),
			.rect        (lanes[g])
		);
	end

	always_comb begin
		for (int i = 0; i < TILE_DIM; i++) begin
			row.lane[i] = lanes[i];
			row.lane[i].emit = lanes[i].emit && row_ok;
		end
		row.top = y0_clip[11:0];
		row.bottom = y1_clip[12:0];
		row.last_row = (row_q == COL_W'(TILE_DIM - 1));
	end

	plbl_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.row_valid (row_valid),
		.row       (row),
		.row_ready (row_ready),
		.tile_done (tile_done),
		.rect_out  (rect_out)
	);

endmodule

FILE: rtl/plbl_lane.sv
// one column lane: decodes a pixel of the current row and clips its span
// uses plbl_pkg

module plbl_lane (
	input  logic [7:0]                plane_low,
	input  logic [7:0]                plane_high,
	input  logic [plbl_pkg::COL_W-1:0] col,
	input  logic                      mirror_x,
	input  logic signed [15:0]        origin_x,
	input  logic [3:0]                pixel_scale,
	input  logic [12:0]               frame_w,
	input  logic [31:0]               color_one,
	input  logic [31:0]               color_two,
	input  logic [31:0]               color_three,
	output plbl_pkg::lane_rect_t      rect
);
	import plbl_pkg::*;

	logic [COL_W-1:0]   bit_sel;
	logic [1:0]         value;
	logic [31:0]        color;
	logic [6:0]         offset;
	logic signed [17:0] x0;
	logic signed [17:0] x1;
	logic signed [17:0] x0_clip;
	logic signed [17:0] x1_clip;
	logic signed [17:0] fw_ext;

	// bit 7 is the leftmost pixel unless mirrored
	assign bit_sel = mirror_x ? col : (COL_W'(TILE_DIM - 1) - col);
	assign value = {plane_high[bit_sel], plane_low[bit_sel]};

	always_comb begin
		case (value)
			2'd1: color = color_one;
			2'd2: color = color_two;
			2'd3: color = color_three;
			default: color = 32'd0;
		endcase
	end

	assign offset = 7'({4'd0, col} * {3'd0, pixel_scale});
	assign x0 = {{2{origin_x[15]}}, origin_x} + {11'd0, offset};
	assign x1 = x0 + {14'd0, pixel_scale};
	assign fw_ext = {5'd0, frame_w};
	assign x0_clip = x0[17] ? 18'sd0 : x0;
	assign x1_clip = (x1 > fw_ext) ? fw_ext : x1;

	always_comb begin
		rect.emit = (value != 2'd0) && (color != 32'd0) && (x0_clip < x1_clip);
		rect.left = x0_clip[11:0];
		rect.right = x1_clip[12:0];
		rect.color = color;
	end

endmodule

FILE: rtl/plbl_merge.sv
// merge stage: holds one decoded row, sends its rectangles in column order,
// keeps one rectangle back so the tile's final one can be marked; uses plbl_pkg, plbl_ifs

module plbl_merge (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 row_valid,
	input  plbl_pkg::row_t       row,
	output logic                 row_ready,
	output logic                 tile_done,
	plbl_rect_if.source          rect_out
);
	import plbl_pkg::*;

	row_t                buf_s1;
	logic [TILE_DIM-1:0] mask_s1;
	logic                have_row_q;
	rect_t               hold_q;
	logic                hold_valid_q;
	rect_t               out_q;
	logic                out_last_q;
	logic                out_valid_q;

	logic                out_free;
	logic [COL_W-1:0]    pick_idx;
	logic [TILE_DIM-1:0] pick_hot;
	logic                has_pick;
	logic                pick_go;
	logic                flush;
	logic                flush_push;
	logic                push;
	logic [TILE_DIM-1:0] mask_next;
	rect_t               picked;

	assign out_free = !out_valid_q || rect_out.ready;

	// lowest set column goes first
	always_comb begin
		pick_idx = '0;
		for (int i = TILE_DIM - 1; i >= 0; i--) begin
			if (mask_s1[i]) begin
				pick_idx = COL_W'(i);
			end
		end
	end

	assign has_pick = |mask_s1;
	assign pick_hot = TILE_DIM'(1) << pick_idx;
	assign pick_go = has_pick && (!hold_valid_q || out_free);
	assign mask_next = pick_go ? (mask_s1 & ~pick_hot) : mask_s1;

	// final row drained: release the held rectangle as the last one
	assign flush = have_row_q && !has_pick && buf_s1.last_row;
	assign flush_push = flush && hold_valid_q && out_free;
	assign tile_done = flush && (!hold_valid_q || out_free);
	assign push = (pick_go && hold_valid_q) || flush_push;

	assign row_ready = !have_row_q || (!buf_s1.last_row && (mask_next == '0));

	always_comb begin
		picked.left = buf_s1.lane[pick_idx].left;
		picked.right = buf_s1.lane[pick_idx].right;
		picked.color = buf_s1.lane[pick_idx].color;
		picked.top = buf_s1.top;
		picked.bottom = buf_s1.bottom;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_row_q <= 1'b0;
			mask_s1 <= '0;
			hold_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (row_valid && row_ready) begin
				have_row_q <= 1'b1;
				for (int i = 0; i < TILE_DIM; i++) begin
					mask_s1[i] <= row.lane[i].emit;
				end
			end else begin
				mask_s1 <= mask_next;
				if (tile_done) begin
					have_row_q <= 1'b0;
				end
			end

			if (pick_go) begin
				hold_valid_q <= 1'b1;
			end else if (flush_push) begin
				hold_valid_q <= 1'b0;
			end

			if (push) begin
				out_valid_q <= 1'b1;
			end else if (rect_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (row_valid && row_ready) begin
			buf_s1 <= row;
		end
		if (pick_go) begin
			hold_q <= picked;
		end
		if (push) begin
			out_q <= hold_q;
			out_last_q <= flush_push;
		end
	end

	assign rect_out.valid = out_valid_q;
	assign rect_out.rect_left = out_q.left;
	assign rect_out.rect_top = out_q.top;
	assign rect_out.rect_right = out_q.right;
	assign rect_out.rect_bottom = out_q.bottom;
	assign rect_out.fill_color = out_q.color;
	assign rect_out.last_rect = out_last_q;

endmodule
